FILE: src/mbe_pkg.sv
package mbe_pkg;

  localparam int FRAC_BITS  = 27;
  localparam int COORD_BITS = 15;
  localparam int STEP_BITS  = 30;
  localparam int ITER_BITS  = 13;
  localparam int GREY_BITS  = 8;
  localparam int APB_AW     = 5;
  localparam int APB_DW     = 32;

  // Iterate width: sign, four integer bits and the fraction.
  localparam int ZW  = FRAC_BITS + 5;
  localparam int DW  = COORD_BITS + 2;
  localparam int VW  = DW + STEP_BITS + 1;
  localparam int SQW = 2 * ZW - FRAC_BITS;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef logic signed [ZW-1:0]     z_t;
  typedef logic signed [DW-1:0]     d_t;
  typedef logic signed [VW-1:0]     v_t;
  typedef logic signed [VW-2:0]     h_t;
  typedef logic signed [2*ZW-1:0]   prod_t;
  typedef logic signed [SQW-1:0]    sq_t;
  typedef logic signed [SQW:0]      len_t;
  typedef logic [QAW-1:0]           qptr_t;
  typedef logic [QCW-1:0]           qcnt_t;

  localparam h_t   SAT_HI = h_t'((longint'(8) <<< FRAC_BITS) - 1);
  localparam h_t   SAT_LO = h_t'(-(longint'(8) <<< FRAC_BITS));
  localparam len_t FOUR   = len_t'(longint'(4) <<< FRAC_BITS);

  localparam logic [COORD_BITS-1:0] WIDTH_RST  = COORD_BITS'(640);
  localparam logic [COORD_BITS-1:0] HEIGHT_RST = COORD_BITS'(480);
  localparam logic [STEP_BITS-1:0]  STEP_RST   = STEP_BITS'(838861);
  localparam logic [ITER_BITS-1:0]  ITER_RST   = ITER_BITS'(256);
  localparam logic [GREY_BITS-1:0]  SHADE_RST  = GREY_BITS'(35);

  typedef enum logic [2:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_STEP,
    REG_MAX_ITER,
    REG_SHADE
  } reg_idx_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] image_width;
    logic [COORD_BITS-1:0] image_height;
    logic [STEP_BITS-1:0]  pixel_step;
    logic [ITER_BITS-1:0]  max_iterations;
    logic [GREY_BITS-1:0]  shade_multiplier;
  } cfg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_col;
    logic [COORD_BITS-1:0] pixel_row;
  } pixel_t;

  typedef struct packed {
    logic [ITER_BITS-1:0] iteration_count;
    logic [GREY_BITS-1:0] grey_level;
  } result_t;

  typedef struct packed {
    z_t c_re;
    z_t c_im;
  } coord_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_RE,
    F_IM,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ADD,
    B_MUL,
    B_DONE
  } back_state_t;

endpackage

FILE: src/mbe_front.sv
module mbe_front (
  input  logic            clk,
  input  logic            rst,
  input  mbe_pkg::cfg_t   cfg,
  input  logic            push,
  output logic            full,
  input  mbe_pkg::pixel_t pixel,
  output logic            q_push,
  input  logic            q_full,
  output mbe_pkg::coord_t q_data
);

  mbe_pkg::front_state_t state, state_next;
  mbe_pkg::pixel_t       pix;
  mbe_pkg::z_t           c_re;
  mbe_pkg::z_t           c_im;

  logic [mbe_pkg::COORD_BITS-1:0] sel_p;
  logic [mbe_pkg::COORD_BITS-1:0] sel_n;
  mbe_pkg::d_t                    d;
  mbe_pkg::v_t                    v;
  mbe_pkg::h_t                    h;
  mbe_pkg::z_t                    c_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbe_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    full       = 1'b1;
    q_push     = 1'b0;
    unique case (state)
      mbe_pkg::F_IDLE: begin
        full = 1'b0;
        if (push) begin
          state_next = mbe_pkg::F_RE;
        end
      end
      mbe_pkg::F_RE: begin
        state_next = mbe_pkg::F_IM;
      end
      mbe_pkg::F_IM: begin
        state_next = mbe_pkg::F_PUSH;
      end
      mbe_pkg::F_PUSH: begin
        if (!q_full) begin
          q_push     = 1'b1;
          state_next = mbe_pkg::F_IDLE;
        end
      end
      default: begin
        state_next = mbe_pkg::F_IDLE;
      end
    endcase
  end

  // One multiplier serves both axes, real axis first.
  always_comb begin
    if (state == mbe_pkg::F_RE) begin
      sel_p = pix.pixel_col;
      sel_n = cfg.image_width;
    end else begin
      sel_p = pix.pixel_row;
      sel_n = cfg.image_height;
    end
    d = $signed({1'b0, sel_p, 1'b0}) - $signed({2'b00, sel_n});
    v = d * $signed({1'b0, cfg.pixel_step});
    h = mbe_pkg::h_t'(v >>> 1);
    if (h > mbe_pkg::SAT_HI) begin
      c_sat = mbe_pkg::z_t'(mbe_pkg::SAT_HI);
    end else if (h < mbe_pkg::SAT_LO) begin
      c_sat = mbe_pkg::z_t'(mbe_pkg::SAT_LO);
    end else begin
      c_sat = mbe_pkg::z_t'(h);
    end
  end

  always_ff @(posedge clk) begin
    if (state == mbe_pkg::F_IDLE && push) begin
      pix <= pixel;
    end
    if (state == mbe_pkg::F_RE) begin
      c_re <= c_sat;
    end
    if (state == mbe_pkg::F_IM) begin
      c_im <= c_sat;
    end
  end

  assign q_data.c_re = c_re;
  assign q_data.c_im = c_im;

endmodule

FILE: src/mbe_queue.sv
module mbe_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  output logic            full,
  input  mbe_pkg::coord_t wdata,
  input  logic            rd,
  output logic            empty,
  output mbe_pkg::coord_t rdata
);

  mbe_pkg::coord_t entries [mbe_pkg::QDEPTH];
  mbe_pkg::qptr_t  wr_ptr;
  mbe_pkg::qptr_t  rd_ptr;
  mbe_pkg::qcnt_t  cnt;
  logic            do_wr;
  logic            do_rd;

  assign full  = (cnt == mbe_pkg::qcnt_t'(mbe_pkg::QDEPTH));
  assign empty = (cnt == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = entries[rd_ptr];

  function automatic mbe_pkg::qptr_t ptr_inc(input mbe_pkg::qptr_t p);
    return (p == mbe_pkg::qptr_t'(mbe_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_rd) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

FILE: src/mbe_back.sv
module mbe_back (
  input  logic             clk,
  input  logic             rst,
  input  mbe_pkg::cfg_t    cfg,
  input  logic             q_empty,
  output logic             q_pop,
  input  mbe_pkg::coord_t  q_data,
  output logic             empty,
  input  logic             pop,
  output mbe_pkg::result_t result
);

  mbe_pkg::back_state_t state, state_next;
  mbe_pkg::z_t          c_re;
  mbe_pkg::z_t          c_im;
  mbe_pkg::z_t          zr;
  mbe_pkg::z_t          zi;
  mbe_pkg::sq_t         sq_r;
  mbe_pkg::sq_t         sq_i;
  mbe_pkg::sq_t         sq_x;
  logic [mbe_pkg::ITER_BITS-1:0] count;
  logic                 out_valid;
  mbe_pkg::result_t     out_reg;

  mbe_pkg::prod_t       p_rr;
  mbe_pkg::prod_t       p_ii;
  mbe_pkg::prod_t       p_ri;
  mbe_pkg::z_t          zr_new;
  mbe_pkg::z_t          zi_new;
  mbe_pkg::len_t        len;
  logic                 finish;
  logic                 res_write;
  logic [2*mbe_pkg::GREY_BITS-1:0] grey_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbe_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign len    = mbe_pkg::len_t'(sq_r) + mbe_pkg::len_t'(sq_i);
  assign finish = (count != '0) && ((len >= mbe_pkg::FOUR) || (count >= cfg.max_iterations));

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    res_write  = 1'b0;
    unique case (state)
      mbe_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = mbe_pkg::B_ADD;
        end
      end
      mbe_pkg::B_ADD: begin
        if (finish) begin
          state_next = mbe_pkg::B_DONE;
        end else begin
          state_next = mbe_pkg::B_MUL;
        end
      end
      mbe_pkg::B_MUL: begin
        state_next = mbe_pkg::B_ADD;
      end
      mbe_pkg::B_DONE: begin
        if (!out_valid || pop) begin
          res_write  = 1'b1;
          state_next = mbe_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = mbe_pkg::B_IDLE;
      end
    endcase
  end

  assign zr_new = mbe_pkg::z_t'(sq_r - sq_i + mbe_pkg::sq_t'(c_re));
  assign zi_new = mbe_pkg::z_t'((sq_x <<< 1) + mbe_pkg::sq_t'(c_im));

  assign p_rr = zr * zr;
  assign p_ii = zi * zi;
  assign p_ri = zr * zi;

  always_ff @(posedge clk) begin
    if (state == mbe_pkg::B_IDLE && !q_empty) begin
      c_re  <= q_data.c_re;
      c_im  <= q_data.c_im;
      sq_r  <= '0;
      sq_i  <= '0;
      sq_x  <= '0;
      count <= '0;
    end
    if (state == mbe_pkg::B_ADD && !finish) begin
      zr    <= zr_new;
      zi    <= zi_new;
      count <= count + 1'b1;
    end
    if (state == mbe_pkg::B_MUL) begin
      sq_r <= mbe_pkg::sq_t'(p_rr >>> mbe_pkg::FRAC_BITS);
      sq_i <= mbe_pkg::sq_t'(p_ii >>> mbe_pkg::FRAC_BITS);
      sq_x <= mbe_pkg::sq_t'(p_ri >>> mbe_pkg::FRAC_BITS);
    end
  end

  assign grey_prod = count[mbe_pkg::GREY_BITS-1:0] * cfg.shade_multiplier;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_write) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_write) begin
      out_reg.iteration_count <= count;
      out_reg.grey_level      <= grey_prod[mbe_pkg::GREY_BITS-1:0];
    end
  end

  assign empty  = !out_valid;
  assign result = out_reg;

endmodule

FILE: src/mandelbrot_escape_pixel.sv
// Escape-time evaluator for one image pixel per request.
// Input channel: drive pixel and raise push; the request is taken at a clock
// edge where push is high and full is low. Result channel: while empty is low,
// result holds the oldest count and grey level; it leaves at an edge where pop
// is high. Configuration is written over the APB port while no request is in
// flight; the user must keep to this, as the block does not enforce it. prdata
// returns the addressed register. The front maps a pixel to its point using
// one multiplier, real part first, then places it in a two-entry queue. The
// back runs each iteration as a multiply state, which forms the squares and
// cross product, then an add state, which forms the new iterate and makes the
// escape test. The back takes a new point from the queue only while idle, once
// the previous result has been written to the output register.
// When the receiver stalls, one result waits in the output register, the back
// holds the next finished one, and the queue and front keep taking requests
// until they are full. A reset empties every stage and restores the registers
// to width 640, height 480, the matching step, limit 256 and shade 35.
module mandelbrot_escape_pixel (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  mbe_pkg::pixel_t             pixel,
  output logic                        empty,
  input  logic                        pop,
  output mbe_pkg::result_t            result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mbe_pkg::APB_AW-1:0]  paddr,
  input  logic [mbe_pkg::APB_DW-1:0]  pwdata,
  output logic [mbe_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  mbe_pkg::cfg_t     cfg;
  mbe_pkg::reg_idx_t reg_idx;
  logic              cfg_wr;
  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_empty;
  mbe_pkg::coord_t   q_wdata;
  mbe_pkg::coord_t   q_rdata;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = mbe_pkg::reg_idx_t'(paddr[mbe_pkg::APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width      <= mbe_pkg::WIDTH_RST;
      cfg.image_height     <= mbe_pkg::HEIGHT_RST;
      cfg.pixel_step       <= mbe_pkg::STEP_RST;
      cfg.max_iterations   <= mbe_pkg::ITER_RST;
      cfg.shade_multiplier <= mbe_pkg::SHADE_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        mbe_pkg::REG_WIDTH:    cfg.image_width      <= pwdata[mbe_pkg::COORD_BITS-1:0];
        mbe_pkg::REG_HEIGHT:   cfg.image_height     <= pwdata[mbe_pkg::COORD_BITS-1:0];
        mbe_pkg::REG_STEP:     cfg.pixel_step       <= pwdata[mbe_pkg::STEP_BITS-1:0];
        mbe_pkg::REG_MAX_ITER: cfg.max_iterations   <= pwdata[mbe_pkg::ITER_BITS-1:0];
        mbe_pkg::REG_SHADE:    cfg.shade_multiplier <= pwdata[mbe_pkg::GREY_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      mbe_pkg::REG_WIDTH:    prdata = mbe_pkg::APB_DW'(cfg.image_width);
      mbe_pkg::REG_HEIGHT:   prdata = mbe_pkg::APB_DW'(cfg.image_height);
      mbe_pkg::REG_STEP:     prdata = mbe_pkg::APB_DW'(cfg.pixel_step);
      mbe_pkg::REG_MAX_ITER: prdata = mbe_pkg::APB_DW'(cfg.max_iterations);
      mbe_pkg::REG_SHADE:    prdata = mbe_pkg::APB_DW'(cfg.shade_multiplier);
      default:               prdata = '0;
    endcase
  end

  mbe_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .push   (push),
    .full   (full),
    .pixel  (pixel),
    .q_push (q_push),
    .q_full (q_full),
    .q_data (q_wdata)
  );

  mbe_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .full  (q_full),
    .wdata (q_wdata),
    .rd    (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  mbe_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_data  (q_rdata),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  a_reset_clears: assert property (@(posedge clk) rst |=> !full && empty)
    else $error("front or result stage not cleared by reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    push && !full |=> full)
    else $error("front took a request but did not become busy");

  a_queue_no_overrun: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("point written into a full queue");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    !empty |-> result.iteration_count != '0)
    else $error("result shows zero iterations");

endmodule
